// File: sv/vvs_pkg.sv
package vvs_pkg;

    localparam int GAUGE_BITS = 10;
    localparam int TIMER_BITS = 16;

    localparam int LINK_TO_BITS  = 16;
    localparam int THRESH_BITS   = 10;
    localparam int VENT_TO_BITS  = 16;
    localparam int INTERVAL_BITS = 8;
    localparam int VALVE_BITS    = 5;
    localparam int CFG_DATA_BITS = 16;

    // compare widths wide enough for both operands
    localparam int TCMP_BITS = (TIMER_BITS > VENT_TO_BITS) ? TIMER_BITS : VENT_TO_BITS;
    localparam int GCMP_BITS = (GAUGE_BITS > THRESH_BITS) ? GAUGE_BITS : THRESH_BITS;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    localparam logic [VALVE_BITS-1:0] VALVE_OUT   = VALVE_BITS'(5'h04);
    localparam logic [VALVE_BITS-1:0] VALVE_SHORT = VALVE_BITS'(5'h10);
    localparam logic [VALVE_BITS-1:0] VALVE_VENT_OPEN = VALVE_OUT | VALVE_SHORT;

    localparam logic [LINK_TO_BITS-1:0]  LINK_TIMEOUT_RST = LINK_TO_BITS'(2000);
    localparam logic [THRESH_BITS-1:0]   VENT_THRESH_RST  = THRESH_BITS'(211);
    localparam logic [VENT_TO_BITS-1:0]  VENT_TIMEOUT_RST = VENT_TO_BITS'(5000);
    localparam logic [INTERVAL_BITS-1:0] VENT_INTVL_RST   = INTERVAL_BITS'(50);

    typedef enum logic [1:0] {
        CFG_LINK_TIMEOUT  = 2'd0,
        CFG_VENT_THRESH   = 2'd1,
        CFG_VENT_TIMEOUT  = 2'd2,
        CFG_VENT_INTERVAL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [LINK_TO_BITS-1:0]  link_timeout_ticks;
        logic [THRESH_BITS-1:0]   vent_pressure_threshold;
        logic [VENT_TO_BITS-1:0]  vent_timeout_ticks;
        logic [INTERVAL_BITS-1:0] vent_check_interval;
    } cfg_t;

    typedef struct packed {
        logic                  host_activity;
        logic                  trigger_mode_request;
        logic                  vent_request;
        logic                  reset_request;
        logic [VALVE_BITS-1:0] valve_requests;
        logic [3:0]            trigger_lines;
        logic [GAUGE_BITS-1:0] gauge_sample;
    } tick_t;

    typedef struct packed {
        logic [VALVE_BITS-1:0] valve_drive;
        logic                  in_trigger_mode;
        logic                  link_up;
        logic                  venting;
        logic                  force_trigger_bit;
        logic                  clear_reset_bit;
        logic                  clear_vent_bit;
        logic                  clear_valve_bits;
    } result_t;

    typedef struct packed {
        logic                     trigger_mode;
        logic                     link_flag;
        logic [TIMER_BITS-1:0]    idle_count;
        logic                     vent_active;
        logic [TIMER_BITS-1:0]    vent_elapsed;
        logic [INTERVAL_BITS-1:0] check_phase;
        logic [VALVE_BITS-1:0]    valve_state;
    } seq_state_t;

    function automatic logic [TIMER_BITS-1:0] count_up(input logic [TIMER_BITS-1:0] v);
        return (v == TIMER_MAX) ? TIMER_MAX : v + TIMER_BITS'(1);
    endfunction

endpackage

// File: sv/vvs_step.sv
// One tick of the sequencer: next state and result from current state.
module vvs_step
    import vvs_pkg::*;
(
    input  seq_state_t st,
    input  cfg_t       cfg,
    input  tick_t      tk,
    output seq_state_t st_next,
    output result_t    res
);

    logic eff_trig;
    logic started;
    logic gauge_low;
    logic elapsed_over;
    logic p_force;
    logic p_clr_reset;
    logic p_clr_vent;
    logic p_clr_valves;
    logic [TIMER_BITS-1:0]    elapsed_inc;
    logic [INTERVAL_BITS-1:0] phase_inc;

    assign gauge_low = GCMP_BITS'(tk.gauge_sample) <= GCMP_BITS'(cfg.vent_pressure_threshold);

    always_comb
    begin
        st_next      = st;
        eff_trig     = tk.trigger_mode_request;
        started      = 1'b0;
        p_force      = 1'b0;
        p_clr_reset  = 1'b0;
        p_clr_vent   = 1'b0;
        p_clr_valves = 1'b0;
        elapsed_inc  = count_up(st.vent_elapsed);
        phase_inc    = st.check_phase + INTERVAL_BITS'(1);
        elapsed_over = (TCMP_BITS'(elapsed_inc) > TCMP_BITS'(cfg.vent_timeout_ticks))
                       || (elapsed_inc == TIMER_MAX);

        if (st.vent_active)
        begin
            st_next.idle_count   = tk.host_activity ? '0 : count_up(st.idle_count);
            st_next.vent_elapsed = elapsed_inc;
            st_next.check_phase  = phase_inc;
            if (phase_inc >= cfg.vent_check_interval)
            begin
                st_next.check_phase = '0;
                if (gauge_low || elapsed_over)
                begin
                    st_next.vent_active = 1'b0;
                    st_next.valve_state = '0;
                    p_clr_vent          = 1'b1;
                    if (tk.reset_request)
                    begin
                        st_next.trigger_mode = 1'b1;
                        p_force      = 1'b1;
                        p_clr_reset  = 1'b1;
                        p_clr_valves = 1'b1;
                    end
                    else
                    begin
                        st_next.valve_state = tk.valve_requests;
                    end
                end
            end
        end
        else
        begin
            if (!st.trigger_mode)
            begin
                if (tk.host_activity)
                begin
                    st_next.idle_count = '0;
                    st_next.link_flag  = 1'b1;
                end
                else
                begin
                    st_next.idle_count = count_up(st.idle_count);
                    if (TCMP_BITS'(st_next.idle_count) > TCMP_BITS'(cfg.link_timeout_ticks))
                    begin
                        // watchdog expiry acts as a system reset
                        st_next.trigger_mode = 1'b1;
                        st_next.valve_state  = '0;
                        st_next.link_flag    = 1'b0;
                        p_force      = 1'b1;
                        p_clr_reset  = 1'b1;
                        p_clr_valves = 1'b1;
                        eff_trig     = 1'b1;
                    end
                end
            end

            if (eff_trig)
            begin
                if (tk.trigger_lines == 4'd0)
                    st_next.valve_state = '0;
                st_next.trigger_mode = 1'b1;
            end
            else
            begin
                if (st.trigger_mode)
                begin
                    st_next.idle_count   = '0;
                    st_next.trigger_mode = 1'b0;
                    st_next.link_flag    = 1'b1;
                end
                if (tk.vent_request)
                begin
                    if (!gauge_low)
                    begin
                        st_next.valve_state  = VALVE_VENT_OPEN;
                        st_next.vent_active  = 1'b1;
                        st_next.vent_elapsed = '0;
                        st_next.check_phase  = '0;
                        started              = 1'b1;
                    end
                    else
                    begin
                        st_next.valve_state = '0;
                        p_clr_vent          = 1'b1;
                    end
                end
                if (!started)
                begin
                    if (tk.reset_request)
                    begin
                        st_next.trigger_mode = 1'b1;
                        st_next.valve_state  = '0;
                        p_force      = 1'b1;
                        p_clr_reset  = 1'b1;
                        p_clr_valves = 1'b1;
                    end
                    else
                    begin
                        st_next.valve_state = tk.valve_requests;
                    end
                end
            end
        end
    end

    always_comb
    begin
        res.valve_drive       = st_next.valve_state;
        res.in_trigger_mode   = st_next.trigger_mode;
        res.link_up           = st_next.link_flag;
        res.venting           = st_next.vent_active;
        res.force_trigger_bit = p_force;
        res.clear_reset_bit   = p_clr_reset;
        res.clear_vent_bit    = p_clr_vent;
        res.clear_valve_bits  = p_clr_valves;
    end

endmodule

// File: sv/valve_mode_and_vent_sequencer_core.sv
// Channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------
// tick     | tick_valid / tick_stall    | tick   (tick_t, one ms sample)
// res      | res_valid / res_stall      | res    (result_t, one per tick)
// cfg      | cfg_valid / cfg_ready      | cfg_index (cfg_idx_t), cfg_data (16b)
//
// A tick transfer is captured in the input register, then the step logic
// loads the result register and the sequencer state together. Throughput is
// one tick per clock while res is not stalled.
// The stall on tick is raised only while the input register holds a tick
// and the result register is full and stalled.
// rst_n (async, active low) restores the register defaults, trigger mode,
// link down, no vent, all valves shut. cfg_ready is always high.
module valve_mode_and_vent_sequencer_core
    import vvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     tick_valid,
    output logic                     tick_stall,
    input  tick_t                    tick,

    output logic                     res_valid,
    input  logic                     res_stall,
    output result_t                  res,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_idx_t                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // input stage
    logic       tick_valid_reg;
    tick_t      tick_reg;

    // result stage
    logic       res_valid_reg;
    result_t    res_reg;

    // sequencer state and configuration
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    cfg_t       cfg_reg;

    logic out_free;
    logic advance;
    logic tick_take;

    // Result register can take a new value when empty or being drained.
    assign out_free   = !res_valid_reg || !res_stall;
    assign advance    = tick_valid_reg && out_free;
    assign tick_stall = tick_valid_reg && !out_free;
    assign tick_take  = tick_valid && !tick_stall;

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    vvs_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .tk      (tick_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // input register: refilled on every transfer, emptied when it moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (tick_take)
            tick_valid_reg <= 1'b1;
        else if (advance)
            tick_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
            tick_reg <= tick;
    end

    // result register and state commit together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.trigger_mode <= 1'b1;
            state_reg.link_flag    <= 1'b0;
            state_reg.idle_count   <= '0;
            state_reg.vent_active  <= 1'b0;
            state_reg.vent_elapsed <= '0;
            state_reg.check_phase  <= '0;
            state_reg.valve_state  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_timeout_ticks      <= LINK_TIMEOUT_RST;
            cfg_reg.vent_pressure_threshold <= VENT_THRESH_RST;
            cfg_reg.vent_timeout_ticks      <= VENT_TIMEOUT_RST;
            cfg_reg.vent_check_interval     <= VENT_INTVL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LINK_TIMEOUT:
                    cfg_reg.link_timeout_ticks <= cfg_data[LINK_TO_BITS-1:0];
                CFG_VENT_THRESH:
                    cfg_reg.vent_pressure_threshold <= cfg_data[THRESH_BITS-1:0];
                CFG_VENT_TIMEOUT:
                    cfg_reg.vent_timeout_ticks <= cfg_data[VENT_TO_BITS-1:0];
                CFG_VENT_INTERVAL:
                    cfg_reg.vent_check_interval <= cfg_data[INTERVAL_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// File: sv/vvs_checker.sv
module vvs_checker
    import vvs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     tick_valid,
    input logic                     tick_stall,
    input tick_t                    tick,
    input logic                     res_valid,
    input logic                     res_stall,
    input result_t                  res,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input cfg_idx_t                 cfg_index,
    input logic [CFG_DATA_BITS-1:0] cfg_data
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // a running vent keeps OUT and SHORT open and nothing else
    a_vent_valves: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.venting |-> res.valve_drive == VALVE_VENT_OPEN)
        else $error("vent running with wrong valves");

    // venting only happens in host mode with the link up
    a_vent_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.venting |-> !res.in_trigger_mode && res.link_up)
        else $error("vent outside host mode");

    // system reset pulses come as a group with valves shut
    a_sys_reset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.force_trigger_bit |->
            res.in_trigger_mode && res.clear_reset_bit && res.clear_valve_bits
            && res.valve_drive == '0)
        else $error("incomplete system reset");

    // vent clear pulse never coexists with a running vent
    a_vent_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.clear_vent_bit |-> !res.venting)
        else $error("vent clear while venting");

endmodule

bind valve_mode_and_vent_sequencer_core vvs_checker u_vvs_checker (.*);
